>>> rtl/core/bhpr_pkg.sv
// Shared constants, codes and types of the Bayer hot pixel removal unit.
// Has no dependencies; every other file in rtl/core refers to it by scoped names.
package bhpr_pkg;

   localparam int MAX_WIDTH     = 4096;
   localparam int SAMPLE_BITS   = 16;
   localparam int COL_BITS      = $clog2(MAX_WIDTH);
   localparam int EW_BITS       = $clog2(MAX_WIDTH + 1);
   localparam int LAG_BITS      = EW_BITS + 2;
   localparam int FW_BITS       = 13;
   localparam int ROW_BITS      = 14;
   localparam int OUT_BITS      = 16;
   localparam int CHAN_BITS     = 2;
   localparam int LANES         = 4;
   localparam int LANE_BITS     = 2;
   localparam int WIN           = 5;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_IDX_BITS  = CSR_ADDR_BITS - 2;

   localparam logic [FW_BITS-1:0]  FRAME_WIDTH_RESET  = 13'd4096;
   localparam logic [ROW_BITS-1:0] FRAME_HEIGHT_RESET = 14'd3072;

   localparam logic [REG_IDX_BITS-1:0] REG_FRAME_WIDTH     = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_FRAME_HEIGHT    = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_GREEN_COL_PHASE = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_GREEN_ROW_PHASE = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_RED_ROW_PHASE   = 3'd4;

   localparam logic [CHAN_BITS-1:0] CHAN_RED   = 2'd0;
   localparam logic [CHAN_BITS-1:0] CHAN_GREEN = 2'd1;
   localparam logic [CHAN_BITS-1:0] CHAN_BLUE  = 2'd2;

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [WIN-1:0][WIN-1:0][SAMPLE_BITS-1:0] window_type;
   typedef logic [LANES-1:0][SAMPLE_BITS-1:0] lanes_type;

   typedef struct packed {
      logic [EW_BITS-1:0]  width;
      logic [ROW_BITS-1:0] height;
      logic                green_col_phase;
      logic                green_row_phase;
      logic                red_row_phase;
   } cfg_type;

   typedef struct packed {
      logic                 emit;
      logic                 border;
      logic                 frame_end;
      logic [CHAN_BITS-1:0] chan;
   } meta_type;

endpackage

>>> rtl/core/bhpr_csr.sv
// Configuration registers of the hot pixel removal unit behind an APB-style port.
// Depends on bhpr_pkg for register indexes, reset values and the cfg_type struct.
module bhpr_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [bhpr_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [bhpr_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [bhpr_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output bhpr_pkg::cfg_type                    cfg,
   output logic                                 restart
);

   localparam int FW = bhpr_pkg::FW_BITS;
   localparam int RB = bhpr_pkg::ROW_BITS;
   localparam int EW = bhpr_pkg::EW_BITS;
   localparam int DW = bhpr_pkg::CSR_DATA_BITS;

   logic [FW-1:0] frame_width_ff;
   logic [RB-1:0] frame_height_ff;
   logic          green_col_phase_ff;
   logic          green_row_phase_ff;
   logic          red_row_phase_ff;
   logic          write;
   logic [bhpr_pkg::REG_IDX_BITS-1:0] index;

   assign write = csr_psel && csr_penable && csr_pwrite;
   assign index = csr_paddr[bhpr_pkg::CSR_ADDR_BITS-1:2];
   assign restart = write && ((index == bhpr_pkg::REG_FRAME_WIDTH) ||
                              (index == bhpr_pkg::REG_FRAME_HEIGHT));

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff     <= bhpr_pkg::FRAME_WIDTH_RESET;
         frame_height_ff    <= bhpr_pkg::FRAME_HEIGHT_RESET;
         green_col_phase_ff <= 1'b0;
         green_row_phase_ff <= 1'b0;
         red_row_phase_ff   <= 1'b0;
      end else if (write) begin
         case (index)
            bhpr_pkg::REG_FRAME_WIDTH:     frame_width_ff     <= csr_pwdata[FW-1:0];
            bhpr_pkg::REG_FRAME_HEIGHT:    frame_height_ff    <= csr_pwdata[RB-1:0];
            bhpr_pkg::REG_GREEN_COL_PHASE: green_col_phase_ff <= csr_pwdata[0];
            bhpr_pkg::REG_GREEN_ROW_PHASE: green_row_phase_ff <= csr_pwdata[0];
            bhpr_pkg::REG_RED_ROW_PHASE:   red_row_phase_ff   <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         bhpr_pkg::REG_FRAME_WIDTH:     csr_prdata = DW'(frame_width_ff);
         bhpr_pkg::REG_FRAME_HEIGHT:    csr_prdata = DW'(frame_height_ff);
         bhpr_pkg::REG_GREEN_COL_PHASE: csr_prdata = DW'(green_col_phase_ff);
         bhpr_pkg::REG_GREEN_ROW_PHASE: csr_prdata = DW'(green_row_phase_ff);
         bhpr_pkg::REG_RED_ROW_PHASE:   csr_prdata = DW'(red_row_phase_ff);
         default:                       csr_prdata = '0;
      endcase
   end

   always_comb begin
      if (frame_width_ff == '0) begin
         cfg.width = EW'(1);
      end else if (int'(frame_width_ff) > bhpr_pkg::MAX_WIDTH) begin
         cfg.width = EW'(bhpr_pkg::MAX_WIDTH);
      end else begin
         cfg.width = EW'(frame_width_ff);
      end
      cfg.height          = (frame_height_ff == '0) ? RB'(1) : frame_height_ff;
      cfg.green_col_phase = green_col_phase_ff;
      cfg.green_row_phase = green_row_phase_ff;
      cfg.red_row_phase   = red_row_phase_ff;
   end

endmodule

>>> rtl/core/bhpr_seq.sv
// Stream sequencer: input and output position counters, drain control and the
// first pipeline register. Depends on bhpr_pkg.
module bhpr_seq (
   input  logic                              clock,
   input  logic                              reset,
   input  bhpr_pkg::cfg_type                 cfg,
   input  logic                              restart,
   input  logic                              accept,
   input  logic                              kind,
   input  bhpr_pkg::sample_type              raw_sample,
   input  logic                              s1_adv,
   output logic                              lb_we,
   output logic [bhpr_pkg::COL_BITS-1:0]     lb_addr,
   output logic [bhpr_pkg::LANE_BITS-1:0]    lb_lane,
   output bhpr_pkg::sample_type              lb_data,
   output logic                              s1_valid,
   output bhpr_pkg::sample_type              s1_sample,
   output logic [bhpr_pkg::LANE_BITS-1:0]    s1_lane,
   output bhpr_pkg::meta_type                s1_meta
);

   localparam int CB = bhpr_pkg::COL_BITS;
   localparam int CW = bhpr_pkg::EW_BITS + 1;
   localparam int RB = bhpr_pkg::ROW_BITS;
   localparam int RW = bhpr_pkg::ROW_BITS + 1;
   localparam int LW = bhpr_pkg::LAG_BITS;
   localparam int LB = bhpr_pkg::LANE_BITS;

   logic [CB-1:0] col_ff, col_in;
   logic [LB-1:0] slot_ff, slot_in;
   logic [CB-1:0] ocol_ff, ocol_in;
   logic [RB-1:0] orow_ff, orow_in;
   logic [LW-1:0] pend_ff, pend_in;
   logic [LW-1:0] gap_ff, gap_in;
   logic          drain_ff, drain_in;

   logic                  s1_valid_ff;
   bhpr_pkg::sample_type  s1_sample_ff;
   logic [LB-1:0]         s1_lane_ff;
   bhpr_pkg::meta_type    s1_meta_ff;

   logic                  push, emit, clear, lead, colour;
   bhpr_pkg::sample_type  sample;
   bhpr_pkg::meta_type    meta;
   logic [LW-1:0]         lag;
   logic [CW-1:0]         width_x, col_inc, ocol_x;
   logic [RW-1:0]         height_x, orow_x;

   assign lag      = LW'({cfg.width, 1'b0}) + LW'(2);
   assign width_x  = CW'(cfg.width);
   assign height_x = RW'(cfg.height);
   assign col_inc  = CW'(col_ff) + CW'(1);
   assign ocol_x   = CW'(ocol_ff);
   assign orow_x   = RW'(orow_ff);

   always_comb begin
      lead = (orow_ff[0] == cfg.green_row_phase) ? ~cfg.green_col_phase
                                                 : cfg.green_col_phase;
      colour = (ocol_ff[0] == lead);
      if (!colour) begin
         meta.chan = bhpr_pkg::CHAN_GREEN;
      end else if (orow_ff[0] == cfg.red_row_phase) begin
         meta.chan = bhpr_pkg::CHAN_RED;
      end else begin
         meta.chan = bhpr_pkg::CHAN_BLUE;
      end
      meta.border = (orow_x < RW'(2)) || (orow_x + RW'(2) >= height_x) ||
                    (ocol_x < CW'(2)) || (ocol_x + CW'(2) >= width_x);
      meta.frame_end = (orow_x + RW'(1) >= height_x) && (ocol_x + CW'(1) >= width_x);
      meta.emit = emit;
   end

   always_comb begin
      push     = 1'b0;
      emit     = 1'b0;
      clear    = 1'b0;
      sample   = raw_sample;
      col_in   = col_ff;
      slot_in  = slot_ff;
      ocol_in  = ocol_ff;
      orow_in  = orow_ff;
      pend_in  = pend_ff;
      gap_in   = gap_ff;
      drain_in = drain_ff;
      if (accept) begin
         if (!kind) begin
            if (!drain_ff) begin
               push = 1'b1;
               emit = (pend_ff >= lag);
               if (!emit) begin
                  pend_in = pend_ff + LW'(1);
               end
            end
         end else if (pend_ff != '0) begin
            push     = 1'b1;
            sample   = '0;
            drain_in = 1'b1;
            gap_in   = gap_ff + LW'(1);
            emit     = ({1'b0, pend_ff} + {1'b0, gap_ff}) >= {1'b0, lag};
            if (emit) begin
               pend_in = pend_ff - LW'(1);
               clear   = (pend_ff == LW'(1));
            end
         end
      end
      if (push) begin
         if (col_inc >= width_x) begin
            col_in  = '0;
            slot_in = slot_ff + LB'(1);
         end else begin
            col_in = col_inc[CB-1:0];
         end
      end
      if (emit) begin
         if (ocol_x + CW'(1) >= width_x) begin
            ocol_in = '0;
            orow_in = (orow_x + RW'(1) >= height_x) ? '0 : orow_ff + RB'(1);
         end else begin
            ocol_in = ocol_ff + CB'(1);
         end
      end
      if (clear || restart) begin
         col_in   = '0;
         slot_in  = '0;
         ocol_in  = '0;
         orow_in  = '0;
         pend_in  = '0;
         gap_in   = '0;
         drain_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         slot_ff  <= '0;
         ocol_ff  <= '0;
         orow_ff  <= '0;
         pend_ff  <= '0;
         gap_ff   <= '0;
         drain_ff <= 1'b0;
      end else begin
         col_ff   <= col_in;
         slot_ff  <= slot_in;
         ocol_ff  <= ocol_in;
         orow_ff  <= orow_in;
         pend_ff  <= pend_in;
         gap_ff   <= gap_in;
         drain_ff <= drain_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= push;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= sample;
         s1_lane_ff   <= slot_ff;
         s1_meta_ff   <= meta;
      end
   end

   assign lb_we     = push;
   assign lb_addr   = col_ff;
   assign lb_lane   = slot_ff;
   assign lb_data   = sample;
   assign s1_valid  = s1_valid_ff;
   assign s1_sample = s1_sample_ff;
   assign s1_lane   = s1_lane_ff;
   assign s1_meta   = s1_meta_ff;

endmodule

>>> rtl/core/bhpr_line_buf.sv
// Four line buffers, one memory bank per line slot, all addressed by column.
// Each bank reads before it writes at the same address. Depends on bhpr_pkg.
module bhpr_line_buf (
   input  logic                              clock,
   input  logic                              we,
   input  logic [bhpr_pkg::COL_BITS-1:0]     addr,
   input  logic [bhpr_pkg::LANE_BITS-1:0]    lane,
   input  bhpr_pkg::sample_type              data,
   output bhpr_pkg::lanes_type               rd
);

   localparam int LB = bhpr_pkg::LANE_BITS;

   for (genvar b = 0; b < bhpr_pkg::LANES; b++) begin : g_bank
      bhpr_pkg::sample_type mem [bhpr_pkg::MAX_WIDTH];
      bhpr_pkg::sample_type rd_ff;

      always_ff @(posedge clock) begin
         if (we) begin
            if (lane == LB'(b)) begin
               mem[addr] <= data;
            end
            rd_ff <= mem[addr];
         end
      end

      assign rd[b] = rd_ff;
   end

endmodule

>>> rtl/core/bhpr_window.sv
// 5x5 sample window fed by the line buffers, with the tag of the pixel at its centre.
// Depends on bhpr_pkg for the window and tag types.
module bhpr_window (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              shift,
   input  logic                              out_free,
   input  bhpr_pkg::lanes_type               rd,
   input  bhpr_pkg::sample_type              s1_sample,
   input  logic [bhpr_pkg::LANE_BITS-1:0]    s1_lane,
   input  bhpr_pkg::meta_type                s1_meta,
   output bhpr_pkg::window_type              win,
   output bhpr_pkg::meta_type                win_meta
);

   localparam int LB = bhpr_pkg::LANE_BITS;
   localparam int W  = bhpr_pkg::WIN;

   bhpr_pkg::window_type  win_ff;
   bhpr_pkg::meta_type    meta_ff;
   logic                  emit_ff, emit_in;
   logic [W-1:0][bhpr_pkg::SAMPLE_BITS-1:0] column;

   always_comb begin
      for (int k = 0; k < W - 1; k++) begin
         column[k] = rd[s1_lane + LB'(k)];
      end
      column[W-1] = s1_sample;
   end

   always_comb begin
      if (shift) begin
         emit_in = s1_meta.emit;
      end else if (out_free) begin
         emit_in = 1'b0;
      end else begin
         emit_in = emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff  <= '0;
         emit_ff <= 1'b0;
      end else begin
         emit_ff <= emit_in;
         if (shift) begin
            for (int r = 0; r < W; r++) begin
               for (int c = 0; c < W - 1; c++) begin
                  win_ff[r][c] <= win_ff[r][c+1];
               end
               win_ff[r][W-1] <= column[r];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         meta_ff <= s1_meta;
      end
   end

   assign win = win_ff;

   always_comb begin
      win_meta      = meta_ff;
      win_meta.emit = emit_ff;
   end

endmodule

>>> rtl/core/bhpr_filter.sv
// Hot pixel test and replacement on the window centre for all three colours.
// Depends on bhpr_pkg for the window and tag types.
module bhpr_filter (
   input  bhpr_pkg::window_type                 win,
   input  bhpr_pkg::meta_type                   win_meta,
   output logic [bhpr_pkg::OUT_BITS-1:0]        corrected
);

   localparam int SB = bhpr_pkg::SAMPLE_BITS;

   function automatic logic lt4(input logic [SB-1:0] v, input logic [SB-1:0] n);
      lt4 = {2'b00, v} < {n, 2'b00};
   endfunction

   function automatic logic lt2(input logic [SB-1:0] v, input logic [SB-1:0] n);
      lt2 = {1'b0, v} < {n, 1'b0};
   endfunction

   logic [SB-1:0] v, result;
   logic          orth4, diag4, diag2, far2, keep;
   logic [SB+1:0] sum_diag, sum_far, sum;

   always_comb begin
      v = win[2][2];
      orth4 = lt4(v, win[1][2]) || lt4(v, win[2][1]) ||
              lt4(v, win[2][3]) || lt4(v, win[3][2]);
      diag4 = lt4(v, win[1][1]) || lt4(v, win[1][3]) ||
              lt4(v, win[3][1]) || lt4(v, win[3][3]);
      diag2 = lt2(v, win[1][1]) || lt2(v, win[1][3]) ||
              lt2(v, win[3][1]) || lt2(v, win[3][3]);
      far2  = lt2(v, win[0][2]) || lt2(v, win[4][2]) ||
              lt2(v, win[2][0]) || lt2(v, win[2][4]);
      sum_diag = (SB+2)'(win[1][1]) + (SB+2)'(win[1][3]) +
                 (SB+2)'(win[3][1]) + (SB+2)'(win[3][3]);
      sum_far  = (SB+2)'(win[0][2]) + (SB+2)'(win[4][2]) +
                 (SB+2)'(win[2][0]) + (SB+2)'(win[2][4]);
      if (win_meta.chan == bhpr_pkg::CHAN_GREEN) begin
         keep = orth4 || diag2;
         sum  = sum_diag;
      end else begin
         keep = orth4 || diag4 || far2;
         sum  = sum_far;
      end
      result = (win_meta.border || keep) ? v : sum[SB+1:2];
      corrected = bhpr_pkg::OUT_BITS'(result);
   end

endmodule

>>> rtl/core/bayer_hot_pixel_removal_unit.sv
// Bayer hot pixel removal: line buffers, 5x5 window, defect test and output register.
// A result passes the s1, window and output registers after the transfer releasing
// it; a pixel leaves 2*width+2 transfers after entry, one per cycle unless stalled.
// Reset is synchronous: counters, window and output clear, registers take their reset
// values, and the line memories start unwritten with no clearing pass.
// Depends on bhpr_pkg, bhpr_csr, bhpr_seq, bhpr_line_buf, bhpr_window, bhpr_filter.
module bayer_hot_pixel_removal_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_kind,
   input  logic [15:0]                          req_raw_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [bhpr_pkg::OUT_BITS-1:0]        rsp_corrected_sample,
   output logic [bhpr_pkg::CHAN_BITS-1:0]       rsp_colour_channel,
   output logic                                 rsp_frame_end,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [bhpr_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [bhpr_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [bhpr_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   bhpr_pkg::cfg_type                     cfg;
   logic                                  restart;
   logic                                  accept, out_free, win_hold, s1_adv, load;
   logic                                  lb_we;
   logic [bhpr_pkg::COL_BITS-1:0]         lb_addr;
   logic [bhpr_pkg::LANE_BITS-1:0]        lb_lane;
   bhpr_pkg::sample_type                  lb_data;
   bhpr_pkg::lanes_type                   rd;
   logic                                  s1_valid;
   bhpr_pkg::sample_type                  s1_sample;
   logic [bhpr_pkg::LANE_BITS-1:0]        s1_lane;
   bhpr_pkg::meta_type                    s1_meta;
   bhpr_pkg::window_type                  win;
   bhpr_pkg::meta_type                    win_meta;
   logic [bhpr_pkg::OUT_BITS-1:0]         corrected;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [bhpr_pkg::OUT_BITS-1:0]         rsp_sample_ff;
   logic [bhpr_pkg::CHAN_BITS-1:0]        rsp_chan_ff;
   logic                                  rsp_end_ff;

   assign csr_pready = 1'b1;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign win_hold  = win_meta.emit && !out_free;
   assign s1_adv    = s1_valid && !win_hold;
   assign req_stall = s1_valid && win_hold;
   assign accept    = req_valid && !req_stall;
   assign load      = win_meta.emit && out_free;

   bhpr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg),
      .restart     (restart)
   );

   bhpr_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .restart    (restart),
      .accept     (accept),
      .kind       (req_kind),
      .raw_sample (req_raw_sample[bhpr_pkg::SAMPLE_BITS-1:0]),
      .s1_adv     (s1_adv),
      .lb_we      (lb_we),
      .lb_addr    (lb_addr),
      .lb_lane    (lb_lane),
      .lb_data    (lb_data),
      .s1_valid   (s1_valid),
      .s1_sample  (s1_sample),
      .s1_lane    (s1_lane),
      .s1_meta    (s1_meta)
   );

   bhpr_line_buf u_line_buf (
      .clock (clock),
      .we    (lb_we),
      .addr  (lb_addr),
      .lane  (lb_lane),
      .data  (lb_data),
      .rd    (rd)
   );

   bhpr_window u_window (
      .clock     (clock),
      .reset     (reset),
      .shift     (s1_adv),
      .out_free  (out_free),
      .rd        (rd),
      .s1_sample (s1_sample),
      .s1_lane   (s1_lane),
      .s1_meta   (s1_meta),
      .win       (win),
      .win_meta  (win_meta)
   );

   bhpr_filter u_filter (
      .win       (win),
      .win_meta  (win_meta),
      .corrected (corrected)
   );

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_sample_ff <= corrected;
         rsp_chan_ff   <= win_meta.chan;
         rsp_end_ff    <= win_meta.frame_end;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_corrected_sample = rsp_sample_ff;
   assign rsp_colour_channel   = rsp_chan_ff;
   assign rsp_frame_end        = rsp_end_ff;

   a_stall_only_on_blocked_output: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while the output register could drain");

   a_output_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_output_fed_by_window: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid)) |-> $past(win_meta.emit))
      else $error("result appeared without a pending pixel in the window");

endmodule
